// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define AST_SAME(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define AST_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dfgw_pkg.sv -----
// Shared constants, codes and interface structs of the graph walk block.
// No dependencies; imported by every module of the block but dfgw_ram.
package dfgw_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES    = 64;
	localparam int RESULT_LIMIT = 16;

	localparam int VTX_W   = 4;                          // vertex field width
	localparam int CNT_W   = 5;                          // vertex_count register width
	localparam int EDGE_W  = $clog2(MAX_EDGES);          // edge index
	localparam int PTR_W   = EDGE_W + 1;                 // edge index or empty marker
	localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);   // stack depth 0..MAX
	localparam int SIDX_W  = $clog2(MAX_VERTICES);       // stack entry index

	localparam logic [PTR_W-1:0] NO_EDGE = PTR_W'(MAX_EDGES);

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// sequencer -> edge store
	typedef struct packed {
		logic              add;     // append edge vtx -> dst
		logic              clr;     // drop all edges
		logic [VTX_W-1:0]  vtx;     // list head lookup / add source
		logic [VTX_W-1:0]  dst;
		logic [EDGE_W-1:0] rd_addr; // edge read, data next cycle
	} store_req_t;

	// edge store -> sequencer
	typedef struct packed {
		logic              full;
		logic              link_pend; // tail link write in flight
		logic [PTR_W-1:0]  head;      // list head of req.vtx
		logic [VTX_W-1:0]  rd_target;
		logic [PTR_W-1:0]  rd_link;
	} store_sts_t;

endpackage

// ----- hw/rtl/dfgw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfgw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/dfgw_store.sv -----
// Edge store: per-vertex list head/tail, edge count, target and link RAMs.
// Depends on dfgw_pkg and dfgw_ram.
module dfgw_store import dfgw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_sts_t sts
);

	logic [PTR_W-1:0]  head_q [MAX_VERTICES];
	logic [PTR_W-1:0]  tail_q [MAX_VERTICES];
	logic [PTR_W-1:0]  used_q;
	logic              link_pend_q;
	logic [EDGE_W-1:0] link_addr_q;
	logic [EDGE_W-1:0] link_edge_q;

	logic [EDGE_W-1:0] new_e;
	logic [PTR_W-1:0]  head_rd;
	logic              head_empty;
	logic              link_we;
	logic [EDGE_W-1:0] link_waddr;
	logic [PTR_W-1:0]  link_wdata;
	logic [VTX_W-1:0]  tgt_rdata;
	logic [PTR_W-1:0]  link_rdata;

	assign new_e      = used_q[EDGE_W-1:0];
	assign head_rd    = head_q[req.vtx];
	assign head_empty = (head_rd >= NO_EDGE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VERTICES; i++) begin
				head_q[i] <= NO_EDGE;
				tail_q[i] <= NO_EDGE;
			end
			used_q      <= '0;
			link_pend_q <= 1'b0;
		end else begin
			link_pend_q <= 1'b0;
			if (req.clr) begin
				for (int i = 0; i < MAX_VERTICES; i++) begin
					head_q[i] <= NO_EDGE;
					tail_q[i] <= NO_EDGE;
				end
				used_q <= '0;
			end else if (req.add) begin
				if (head_empty) begin
					head_q[req.vtx] <= {1'b0, new_e};
				end else begin
					link_pend_q <= 1'b1;
				end
				tail_q[req.vtx] <= {1'b0, new_e};
				used_q          <= used_q + PTR_W'(1);
			end
		end
	end

	// old tail gets linked to the new edge in the cycle after the add
	always_ff @(posedge clk) begin
		if (req.add) begin
			link_addr_q <= tail_q[req.vtx][EDGE_W-1:0];
			link_edge_q <= new_e;
		end
	end

	assign link_we    = req.add | link_pend_q;
	assign link_waddr = link_pend_q ? link_addr_q : new_e;
	assign link_wdata = link_pend_q ? {1'b0, link_edge_q} : NO_EDGE;

	dfgw_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_target_ram (
		.clk   (clk),
		.we    (req.add),
		.waddr (new_e),
		.wdata (req.dst),
		.raddr (req.rd_addr),
		.rdata (tgt_rdata)
	);

	dfgw_ram #(.WIDTH(PTR_W), .DEPTH(MAX_EDGES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (req.rd_addr),
		.rdata (link_rdata)
	);

	always_comb begin
		sts.full      = (used_q >= PTR_W'(MAX_EDGES));
		sts.link_pend = link_pend_q;
		sts.head      = head_rd;
		sts.rd_target = tgt_rdata;
		sts.rd_link   = link_rdata;
	end

endmodule

// ----- hw/rtl/dfgw_seq.sv -----
// Command sequencer: edge add/clear handling and the stack-based walk.
// Depends on dfgw_pkg; drives dfgw_store through store_req_t.
module dfgw_seq import dfgw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       cmd,
	input  logic [VTX_W-1:0] src_vertex,
	input  logic [VTX_W-1:0] dst_vertex,
	input  logic [CNT_W-1:0] n,
	output logic             busy,
	output logic             valid,
	output logic [VTX_W-1:0] visited_vertex,
	output logic [1:0]       status,
	output logic             last,
	output store_req_t       req,
	input  store_sts_t       sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROOT,
		S_TOP,
		S_EDGE
	} state_t;

	state_t                     state_q;
	logic                       valid_q;
	logic [VTX_W-1:0]           vtx_q;
	status_t                    status_q;
	logic                       last_q;
	logic [MAX_VERTICES-1:0]    visited_q;
	logic [DEPTH_W-1:0]         depth_q;
	logic [CNT_W-1:0]           root_q;
	logic [DEPTH_W-1:0]         count_q;
	logic                       pend_q;
	logic [VTX_W-1:0]           pend_vtx_q;
	logic [PTR_W-1:0]           stk_q [MAX_VERTICES];

	logic             accept;
	cmd_t             op;
	logic             range_bad;
	logic [VTX_W-1:0] root_v;
	logic             root_in;
	logic [SIDX_W-1:0] top_idx;
	logic [PTR_W-1:0] top_ptr;
	logic [VTX_W-1:0] t;
	logic             t_ok;
	logic             emit_en;
	logic [VTX_W-1:0] emit_v;

	assign busy      = (state_q != S_IDLE) | sts.link_pend;
	assign accept    = start & ~busy;
	assign op        = cmd_t'(cmd);
	assign range_bad = ({1'b0, src_vertex} >= n) || ({1'b0, dst_vertex} >= n);
	assign root_v    = root_q[VTX_W-1:0];
	assign root_in   = (root_q < n);
	assign top_idx   = depth_q[SIDX_W-1:0] - SIDX_W'(1);
	assign top_ptr   = stk_q[top_idx];
	assign t         = sts.rd_target;
	assign t_ok      = ({1'b0, t} < n) && !visited_q[t]
		&& (depth_q < DEPTH_W'(MAX_VERTICES)) && (count_q < DEPTH_W'(RESULT_LIMIT));

	always_comb begin
		emit_en = 1'b0;
		emit_v  = t;
		case (state_q)
			S_ROOT: begin
				emit_en = root_in && !visited_q[root_v];
				emit_v  = root_v;
			end
			S_EDGE: begin
				emit_en = t_ok;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		req.add     = accept && (op == CMD_ADD) && !range_bad && !sts.full;
		req.clr     = accept && (op == CMD_CLEAR);
		req.dst     = dst_vertex;
		req.rd_addr = top_ptr[EDGE_W-1:0];
		case (state_q)
			S_ROOT:  req.vtx = root_v;
			S_EDGE:  req.vtx = t;
			default: req.vtx = src_vertex;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= 1'b0;
			vtx_q      <= '0;
			status_q   <= ST_OK;
			last_q     <= 1'b0;
			visited_q  <= '0;
			depth_q    <= '0;
			root_q     <= '0;
			count_q    <= '0;
			pend_q     <= 1'b0;
			pend_vtx_q <= '0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							CMD_ADD: begin
								valid_q <= 1'b1;
								vtx_q   <= '0;
								last_q  <= 1'b1;
								if (range_bad) begin
									status_q <= ST_RANGE;
								end else if (sts.full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
								end
							end
							CMD_RUN: begin
								visited_q <= '0;
								depth_q   <= '0;
								root_q    <= '0;
								count_q   <= '0;
								pend_q    <= 1'b0;
								state_q   <= S_ROOT;
							end
							CMD_CLEAR: begin
								valid_q  <= 1'b1;
								vtx_q    <= '0;
								status_q <= ST_OK;
								last_q   <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_ROOT: begin
					if (!root_in) begin
						// walk done: the held result is the final one
						if (pend_q) begin
							valid_q  <= 1'b1;
							vtx_q    <= pend_vtx_q;
							status_q <= ST_OK;
							last_q   <= 1'b1;
						end
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						root_q <= root_q + CNT_W'(1);
						if (!visited_q[root_v]) begin
							visited_q[root_v] <= 1'b1;
							depth_q           <= DEPTH_W'(1);
							count_q           <= count_q + DEPTH_W'(1);
							state_q           <= S_TOP;
						end
					end
				end
				S_TOP: begin
					if (depth_q == '0) begin
						state_q <= S_ROOT;
					end else if (top_ptr >= NO_EDGE) begin
						depth_q <= depth_q - DEPTH_W'(1);
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if (t_ok) begin
						visited_q[t] <= 1'b1;
						depth_q      <= depth_q + DEPTH_W'(1);
						count_q      <= count_q + DEPTH_W'(1);
					end
					state_q <= S_TOP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// a new visit releases the held one as a non-final result
			if (emit_en) begin
				if (pend_q) begin
					valid_q  <= 1'b1;
					vtx_q    <= pend_vtx_q;
					status_q <= ST_OK;
					last_q   <= 1'b0;
				end
				pend_q     <= 1'b1;
				pend_vtx_q <= emit_v;
			end
		end
	end

	// walk stack: next-edge pointer per level
	always_ff @(posedge clk) begin
		case (state_q)
			S_ROOT: begin
				if (emit_en) begin
					stk_q[0] <= sts.head;
				end
			end
			S_EDGE: begin
				stk_q[top_idx] <= sts.rd_link;
				if (t_ok) begin
					stk_q[depth_q[SIDX_W-1:0]] <= sts.head;
				end
			end
			default: begin
			end
		endcase
	end

	assign valid          = valid_q;
	assign visited_vertex = vtx_q;
	assign status         = status_q;
	assign last           = last_q;

endmodule

// ----- hw/rtl/depth_first_graph_walk.sv -----
// Top level of the depth-first graph walk: vertex count register,
// edge store and command sequencer. Depends on dfgw_pkg, dfgw_store, dfgw_seq.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------
//  request   cmd, src_vertex, dst_vertex             start & !busy
//  result    visited_vertex, status, last            valid, one cycle, no stall
//  config    cfg_wdata (vertex_count)                cfg_we
//
// Add edge: result in the cycle after the request; when the edge is appended to
// a non-empty list, busy stays high while the old tail's link is written.
// Clear: result one cycle after the request, all lists emptied at once.
// Run: busy while the sequencer tries every root in order and scans the edge
// lists one step per cycle through the single read port of the edge RAMs,
// pushing a stack level per newly visited vertex and popping it at list end.
// Results of a run trail their visit by one vertex, the last one is flagged.
// Reset empties all lists and sets vertex_count to 16; no clearing pass.
module depth_first_graph_walk import dfgw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       cmd,
	input  logic [VTX_W-1:0] src_vertex,
	input  logic [VTX_W-1:0] dst_vertex,
	output logic             valid,
	output logic [VTX_W-1:0] visited_vertex,
	output logic [1:0]       status,
	output logic             last,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	logic [CNT_W-1:0] vertex_count_q;
	logic [CNT_W-1:0] n_eff;
	store_req_t       req;
	store_sts_t       sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CNT_W'(16);
		end else if (cfg_we) begin
			vertex_count_q <= cfg_wdata;
		end
	end

	// effective vertex count, clipped to the table size
	assign n_eff = (vertex_count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
		: vertex_count_q;

	dfgw_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts)
	);

	dfgw_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.cmd            (cmd),
		.src_vertex     (src_vertex),
		.dst_vertex     (dst_vertex),
		.n              (n_eff),
		.busy           (busy),
		.valid          (valid),
		.visited_vertex (visited_vertex),
		.status         (status),
		.last           (last),
		.req            (req),
		.sts            (sts)
	);

endmodule

// ----- hw/rtl/dfgw_checker.sv -----
// Port-level checks of the graph walk block, bound to the top level.
// Depends on dfgw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dfgw_checker import dfgw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       cmd,
	input logic             valid,
	input logic [VTX_W-1:0] visited_vertex,
	input logic [1:0]       status,
	input logic             last
);

	logic acc;
	assign acc = start && !busy;

	`AST_NEXT(a_single_result, clk, arst_n, acc && (cmd == CMD_ADD || cmd == CMD_CLEAR), valid && last, "add/clear request must answer next cycle with last")
	`AST_SAME(a_err_is_last, clk, arst_n, valid && status != ST_OK, last && visited_vertex == '0, "error status only on a single add result")
	`AST_NEXT(a_run_busy, clk, arst_n, acc && cmd == CMD_RUN, busy, "run request must hold busy")
	`AST_SAME(a_mid_walk_busy, clk, arst_n, valid && !last, busy, "non-final walk result while idle")

endmodule

bind depth_first_graph_walk dfgw_checker u_dfgw_checker (.*);

// ----- test/depth_first_graph_walk_tb.sv -----
// Self-checking testbench for depth_first_graph_walk: directed and random requests
// against an in-bench model of the edge lists and the walk. Depends on dfgw_pkg and the RTL.
module depth_first_graph_walk_tb;
	import dfgw_pkg::*;

	// Result as the block presents it, one per strobe.
	typedef struct {
		logic [VTX_W-1:0] vtx;
		status_t          st;
		logic             last;
	} walk_answer_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       cmd;
	logic [VTX_W-1:0] src_vertex;
	logic [VTX_W-1:0] dst_vertex;
	logic             valid;
	logic [VTX_W-1:0] visited_vertex;
	logic [1:0]       status;
	logic             last;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	// Model of the graph held by the block.
	logic [VTX_W-1:0] arc_dst  [MAX_EDGES];
	logic [PTR_W-1:0] arc_next [MAX_EDGES];
	logic [PTR_W-1:0] list_first [MAX_VERTICES];
	logic [PTR_W-1:0] list_end   [MAX_VERTICES];
	int               arcs_stored;
	logic [CNT_W-1:0] vcount;

	walk_answer_t predicted_answers[$];
	int           mismatches;
	int           requests_sent;
	bit           allow_gaps;

	localparam int RANDOM_ITEMS   = 240;
	localparam int SETTLE_CYCLES  = 16;

	depth_first_graph_walk DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.src_vertex     (src_vertex),
		.dst_vertex     (dst_vertex),
		.valid          (valid),
		.visited_vertex (visited_vertex),
		.status         (status),
		.last           (last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

	// Vertices in use: register value clamped to the table size.
	function automatic int active_vertices();
		return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
	endfunction

	task automatic empty_lists();
		for (int v = 0; v < MAX_VERTICES; v++) begin
			list_first[v] = NO_EDGE;
			list_end[v]   = NO_EDGE;
		end
		arcs_stored = 0;
	endtask

	// Range check first, then the full check; nothing stored on either.
	function automatic status_t append_arc(logic [VTX_W-1:0] s, logic [VTX_W-1:0] d);
		int n;
		int e;
		n = active_vertices();
		if (s >= n || d >= n)
			return ST_RANGE;
		if (arcs_stored >= MAX_EDGES)
			return ST_FULL;
		e = arcs_stored;
		arc_dst[e]  = d;
		arc_next[e] = NO_EDGE;
		if (list_first[s] == NO_EDGE)
			list_first[s] = PTR_W'(e);
		else
			arc_next[list_end[s][EDGE_W-1:0]] = PTR_W'(e);
		list_end[s] = PTR_W'(e);
		arcs_stored = e + 1;
		return ST_OK;
	endfunction

	// Depth-first walk from every unvisited root in order; one answer per new vertex.
	task automatic predict_walk();
		int               n;
		int               depth;
		int               top;
		int               found;
		logic [PTR_W-1:0] ptr;
		logic [VTX_W-1:0] t;
		bit               seen [MAX_VERTICES];
		logic [PTR_W-1:0] resume [MAX_VERTICES];
		walk_answer_t     batch[$];
		walk_answer_t     a;
		n = active_vertices();
		found = 0;
		for (int v = 0; v < MAX_VERTICES; v++)
			seen[v] = 1'b0;
		for (int root = 0; root < n; root++) begin
			if (seen[root])
				continue;
			seen[root] = 1'b1;
			a.vtx = VTX_W'(root);
			a.st = ST_OK;
			a.last = 1'b0;
			batch.push_back(a);
			found++;
			resume[0] = list_first[root];
			depth = 1;
			while (depth > 0) begin
				top = depth - 1;
				ptr = resume[top];
				if (ptr >= MAX_EDGES) begin
					depth = top;
					continue;
				end
				t = arc_dst[ptr[EDGE_W-1:0]];
				resume[top] = arc_next[ptr[EDGE_W-1:0]];
				// stale targets beyond the vertex count are skipped
				if (t < n && !seen[t] && depth < MAX_VERTICES && found < RESULT_LIMIT) begin
					seen[t] = 1'b1;
					a.vtx = t;
					a.st = ST_OK;
					a.last = 1'b0;
					batch.push_back(a);
					found++;
					resume[depth] = list_first[t];
					depth++;
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			predicted_answers.push_back(batch[i]);
	endtask

	task automatic predict_request(cmd_t c, logic [VTX_W-1:0] s, logic [VTX_W-1:0] d);
		walk_answer_t a;
		a.vtx = '0;
		a.last = 1'b1;
		a.st = ST_OK;
		case (c)
			CMD_ADD: begin
				a.st = append_arc(s, d);
				predicted_answers.push_back(a);
			end
			CMD_RUN: begin
				predict_walk();
			end
			CMD_CLEAR: begin
				empty_lists();
				predicted_answers.push_back(a);
			end
			default: begin
				// unused code: no answer, no state change
			end
		endcase
	endtask

	// Every task is entered and left just after a falling edge.
	// start stays high across back-to-back requests.
	task automatic send_request(cmd_t c, logic [VTX_W-1:0] s, logic [VTX_W-1:0] d);
		int gap;
		gap = 0;
		if (allow_gaps && $urandom_range(0, 99) < 32)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		cmd        <= c;
		src_vertex <= s;
		dst_vertex <= d;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		// answers come in the cycle after acceptance at the earliest
		@(negedge clk);
		predict_request(c, s, d);
		requests_sent++;
	endtask

	// Drain to idle, then let any result-less tail of a run finish.
	task automatic wait_idle();
		start <= 1'b0;
		forever begin
			@(posedge clk);
			if (predicted_answers.size() == 0 && !busy)
				break;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_vertex_count(logic [CNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		vcount = value;
	endtask

	// Result checker: every strobe is matched against the oldest prediction.
	always @(posedge clk) begin
		walk_answer_t a;
		if (arst_n && valid) begin
			if (predicted_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: vertex %0d status %0d last %0b",
						visited_vertex, status, last);
			end else begin
				a = predicted_answers.pop_front();
				if (a.vtx !== visited_vertex || a.st !== status_t'(status) || a.last !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp vertex %0d status %0d last %0b, got %0d %0d %0b",
							a.vtx, a.st, a.last, visited_vertex, status, last);
				end
			end
		end
	end

	// Outer vertices, self loops and list order on the full vertex range.
	task automatic test_basic_arcs();
		set_vertex_count(5'd16);
		send_request(CMD_ADD, 4'd0, 4'd15);
		send_request(CMD_ADD, 4'd15, 4'd0);
		send_request(CMD_ADD, 4'd15, 4'd15);
		send_request(CMD_ADD, 4'd0, 4'd0);
		send_request(CMD_ADD, 4'd3, 4'd7);
		send_request(CMD_ADD, 4'd0, 4'd3);
		send_request(CMD_RUN, 4'd0, 4'd0);
	endtask

	// Shrunk count: range errors on both ends, stale arcs left in place.
	task automatic test_range_and_stale();
		set_vertex_count(5'd5);
		send_request(CMD_ADD, 4'd7, 4'd1);
		send_request(CMD_ADD, 4'd1, 4'd9);
		send_request(CMD_ADD, 4'd4, 4'd4);
		send_request(CMD_RUN, 4'd0, 4'd0);
		send_request(CMD_NONE, 4'd15, 4'd15);
		send_request(CMD_CLEAR, 4'd0, 4'd0);
		send_request(CMD_RUN, 4'd0, 4'd0);
	endtask

	// No vertices: adds fail on range, a run says nothing.
	task automatic test_zero_count();
		set_vertex_count(5'd0);
		send_request(CMD_ADD, 4'd0, 4'd0);
		send_request(CMD_RUN, 4'd0, 4'd0);
	endtask

	// Register above the table size clamps to 16; a single vertex graph.
	task automatic test_count_limits();
		set_vertex_count(5'd31);
		send_request(CMD_ADD, 4'd15, 4'd14);
		send_request(CMD_RUN, 4'd0, 4'd0);
		set_vertex_count(5'd1);
		send_request(CMD_ADD, 4'd0, 4'd0);
		send_request(CMD_ADD, 4'd0, 4'd1);
		send_request(CMD_RUN, 4'd0, 4'd0);
	endtask

	// Fill the arc table past its end, then walk the dense graph.
	task automatic test_table_full();
		set_vertex_count(5'd16);
		send_request(CMD_CLEAR, 4'd0, 4'd0);
		repeat (MAX_EDGES + 2)
			send_request(CMD_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		send_request(CMD_RUN, 4'd0, 4'd0);
		send_request(CMD_CLEAR, 4'd0, 4'd0);
	endtask

	// Mostly build-and-walk phases with random graphs, plus noise requests.
	task automatic test_random_graphs();
		int goal;
		int r;
		int n;
		int arcs;
		goal = requests_sent + RANDOM_ITEMS;
		while (requests_sent < goal) begin
			// one stretch without random idle gaps between requests
			allow_gaps = !(requests_sent > goal - RANDOM_ITEMS + 120 &&
				requests_sent < goal - RANDOM_ITEMS + 200);
			r = $urandom_range(0, 99);
			if (r < 40)
				set_vertex_count(5'($urandom_range(2, 16)));
			else if (r < 48)
				set_vertex_count(5'd1);
			else if (r < 54)
				set_vertex_count(5'd0);
			else if (r < 62)
				set_vertex_count(5'($urandom_range(17, 31)));
			else if (r < 68)
				set_vertex_count(5'd16);
			if ($urandom_range(0, 99) < 75)
				send_request(CMD_CLEAR, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			n = active_vertices();
			arcs = $urandom_range(0, 20);
			repeat (arcs) begin
				r = $urandom_range(0, 99);
				if (r < 8 || n == 0)
					send_request(CMD_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				else if (r < 12)
					send_request(CMD_NONE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				else if (r < 14)
					send_request(CMD_CLEAR, 4'd0, 4'd0);
				else if (r < 17)
					send_request(CMD_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				else
					send_request(CMD_ADD, 4'($urandom_range(0, n - 1)),
						4'($urandom_range(0, n - 1)));
			end
			send_request(CMD_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 99) < 30)
				send_request(CMD_RUN, 4'd0, 4'd0);
		end
		allow_gaps = 1'b1;
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = CMD_NONE;
		src_vertex = '0;
		dst_vertex = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		mismatches = 0;
		requests_sent = 0;
		allow_gaps = 1'b1;
		vcount = 5'd16;
		empty_lists();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_arcs();
		test_range_and_stale();
		test_zero_count();
		test_count_limits();
		test_table_full();
		test_random_graphs();

		// drain, then give a trailing run time to show any stray strobe
		wait_idle();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && predicted_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dfgw_pkg.sv
hw/rtl/dfgw_ram.sv
hw/rtl/dfgw_store.sv
hw/rtl/dfgw_seq.sv
hw/rtl/depth_first_graph_walk.sv
hw/rtl/dfgw_checker.sv
test/depth_first_graph_walk_tb.sv
